### rtl/assert_macros.svh
// Assertion macros used by the top level of the scan gap finder.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ssgf_pkg.sv
// Package of the scan gap finder: field widths, register codes, the slot tag
// and the reciprocal table of the averaging divider. No dependencies.
package ssgf_pkg;

   localparam int DATA_W      = 16;  // range samples, Q6.10 metres
   localparam int GAP_W       = 11;  // gap index field
   localparam int RSP_TDATA_W = 32;  // result tdata, padded to whole bytes
   localparam int RSP_PAD_W   = RSP_TDATA_W - GAP_W - DATA_W;
   localparam int RECIP_SHIFT = 20;  // fraction bits of the reciprocals
   localparam int RECIP_W     = 21;
   localparam int RECIP_IDX_W = 4;   // sample counts up to nine

   localparam logic [DATA_W-1:0] MIN_VALID_RESET = 16'd102;    // 0.1 m
   localparam logic [DATA_W-1:0] MAX_RANGE_RESET = 16'd20480;  // 20 m

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_MIN_VALID_RANGE = 1'b0,
      CSR_MAX_RANGE       = 1'b1
   } csr_reg_type;

   // Control bits that travel with one smoothed bin down the pipeline.
   typedef struct packed {
      logic valid;  // slot carries a smoothed bin
      logic done;   // last slot of a scan, the result follows
      logic first;  // bin zero of the scan
   } slot_tag_type;

   // floor(2^RECIP_SHIFT / count) for the window sample count.
   function automatic logic [RECIP_W-1:0] recip(input logic [RECIP_IDX_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 21'd1048576;
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349525;
         4'd4:    r = 21'd262144;
         4'd5:    r = 21'd209715;
         4'd6:    r = 21'd174762;
         4'd7:    r = 21'd149796;
         4'd8:    r = 21'd131072;
         4'd9:    r = 21'd116508;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/ssgf_window.sv
// Sample cleaning, window registers, end-of-scan drain and window sum.
// Depends on ssgf_pkg; produces the first pipeline register of the finder.
module ssgf_window #(
   parameter int NUM_BINS      = 1080,
   parameter int SMOOTH_WINDOW = 5
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          accept,
   input  logic [ssgf_pkg::DATA_W-1:0]                   range_sample,
   input  logic                                          last_bin,
   input  logic [ssgf_pkg::DATA_W-1:0]                   min_valid_range,
   input  logic [ssgf_pkg::DATA_W-1:0]                   clamp_range,
   output logic                                          last_eff,
   output logic                                          tail_hold,
   output ssgf_pkg::slot_tag_type                        s1_tag,
   output logic [$clog2(NUM_BINS)-1:0]                   s1_j,
   output logic [ssgf_pkg::DATA_W+$clog2(2*(SMOOTH_WINDOW/2)+1)-1:0] s1_sum,
   output logic [$clog2(2*(SMOOTH_WINDOW/2)+2)-1:0]      s1_cnt
);

   localparam int DATA_W = ssgf_pkg::DATA_W;
   localparam int HALF   = SMOOTH_WINDOW / 2;
   localparam int SPAN   = 2 * HALF + 1;
   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int CNT_W  = $clog2(SPAN + 1);
   localparam int SUM_W  = DATA_W + $clog2(SPAN);
   localparam int TAIL_W = $clog2(HALF + 2);

   logic [IDX_W-1:0]  bin_cnt_ff;
   logic [DATA_W-1:0] win_ff [SPAN];
   logic [SPAN-1:0]   win_vld_ff;
   logic [DATA_W-1:0] tail_ff [SPAN];
   logic [SPAN-1:0]   tail_vld_ff;
   logic [TAIL_W-1:0] tail_cnt_ff;
   logic [IDX_W-1:0]  tail_j_ff;
   logic              emit_ff;
   logic [IDX_W-1:0]  emit_j_ff;

   ssgf_pkg::slot_tag_type s1_tag_ff, s1_tag_in;
   logic [IDX_W-1:0]       s1_j_ff, s1_j_in;
   logic [SUM_W-1:0]       s1_sum_ff, s1_sum_in;
   logic [CNT_W-1:0]       s1_cnt_ff, s1_cnt_in;

   logic [DATA_W-1:0] clean;
   logic [DATA_W-1:0] shift_win [SPAN];
   logic [SPAN-1:0]   shift_vld;
   logic [IDX_W-1:0]  center_j;
   logic              reach;
   logic              use_tail;

   // Out-of-limit samples are replaced by the maximum range.
   assign clean = (range_sample < min_valid_range || range_sample > clamp_range)
                  ? clamp_range : range_sample;

   // A scan also ends at bin NUM_BINS - 1, the last bin of a full scan.
   assign last_eff  = last_bin || (bin_cnt_ff == IDX_W'(NUM_BINS - 1));
   assign tail_hold = tail_cnt_ff > TAIL_W'(1);
   assign center_j  = bin_cnt_ff - IDX_W'(HALF);
   assign reach     = bin_cnt_ff >= IDX_W'(HALF);
   assign use_tail  = tail_cnt_ff != '0;

   // Window after the new sample shifts in, newest at position zero.
   always_comb begin
      shift_win[0] = clean;
      for (int k = 1; k < SPAN; k++) begin
         shift_win[k] = win_ff[k-1];
      end
      shift_vld = {win_vld_ff[SPAN-2:0], 1'b1};
   end

   // Masked window sum and sample count of the bin centered in the window.
   always_comb begin
      s1_sum_in = '0;
      s1_cnt_in = '0;
      for (int k = 0; k < SPAN; k++) begin
         if (use_tail ? tail_vld_ff[k] : win_vld_ff[k]) begin
            s1_sum_in = s1_sum_in + SUM_W'(use_tail ? tail_ff[k] : win_ff[k]);
            s1_cnt_in = s1_cnt_in + CNT_W'(1);
         end
      end
      s1_j_in         = use_tail ? tail_j_ff : emit_j_ff;
      s1_tag_in.valid = use_tail ? tail_vld_ff[HALF] : emit_ff;
      s1_tag_in.done  = use_tail && (tail_cnt_ff == TAIL_W'(1));
      s1_tag_in.first = s1_j_in == '0;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff  <= '0;
         win_vld_ff  <= '0;
         tail_vld_ff <= '0;
         tail_cnt_ff <= '0;
         emit_ff     <= 1'b0;
         s1_tag_ff   <= '0;
      end else if (adv) begin
         if (accept) begin
            bin_cnt_ff <= last_eff ? '0 : bin_cnt_ff + IDX_W'(1);
            win_vld_ff <= last_eff ? '0 : shift_vld;
         end
         emit_ff <= accept && !last_eff && reach;
         // The closing window drains one empty slot at a time.
         if (accept && last_eff) begin
            tail_cnt_ff <= TAIL_W'(HALF + 1);
            tail_vld_ff <= shift_vld;
         end else if (use_tail) begin
            tail_cnt_ff <= tail_cnt_ff - TAIL_W'(1);
            tail_vld_ff <= {tail_vld_ff[SPAN-2:0], 1'b0};
         end
         s1_tag_ff <= s1_tag_in;
      end
   end

   // Sample storage and stage payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         if (accept) begin
            for (int k = 0; k < SPAN; k++) begin
               win_ff[k] <= shift_win[k];
            end
            emit_j_ff <= center_j;
         end
         if (accept && last_eff) begin
            for (int k = 0; k < SPAN; k++) begin
               tail_ff[k] <= shift_win[k];
            end
            tail_j_ff <= center_j;
         end else if (use_tail) begin
            for (int k = SPAN - 1; k > 0; k--) begin
               tail_ff[k] <= tail_ff[k-1];
            end
            tail_ff[0] <= '0;
            tail_j_ff  <= tail_j_ff + IDX_W'(1);
         end
         s1_j_ff   <= s1_j_in;
         s1_sum_ff <= s1_sum_in;
         s1_cnt_ff <= s1_cnt_in;
      end
   end

   assign s1_tag = s1_tag_ff;
   assign s1_j   = s1_j_ff;
   assign s1_sum = s1_sum_ff;
   assign s1_cnt = s1_cnt_ff;

endmodule

### rtl/ssgf_divide.sv
// Truncating division of the window sum by the sample count, in two stages:
// reciprocal multiply, then one correction step. Depends on ssgf_pkg.
module ssgf_divide #(
   parameter int NUM_BINS      = 1080,
   parameter int SMOOTH_WINDOW = 5
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  ssgf_pkg::slot_tag_type                        s1_tag,
   input  logic [$clog2(NUM_BINS)-1:0]                   s1_j,
   input  logic [ssgf_pkg::DATA_W+$clog2(2*(SMOOTH_WINDOW/2)+1)-1:0] s1_sum,
   input  logic [$clog2(2*(SMOOTH_WINDOW/2)+2)-1:0]      s1_cnt,
   output ssgf_pkg::slot_tag_type                        s3_tag,
   output logic [$clog2(NUM_BINS)-1:0]                   s3_j,
   output logic [ssgf_pkg::DATA_W-1:0]                   s3_avg
);

   localparam int DATA_W  = ssgf_pkg::DATA_W;
   localparam int HALF    = SMOOTH_WINDOW / 2;
   localparam int SPAN    = 2 * HALF + 1;
   localparam int IDX_W   = $clog2(NUM_BINS);
   localparam int CNT_W   = $clog2(SPAN + 1);
   localparam int SUM_W   = DATA_W + $clog2(SPAN);
   localparam int RIW     = ssgf_pkg::RECIP_IDX_W;
   localparam int PROD_W  = SUM_W + ssgf_pkg::RECIP_W;
   localparam int SHIFT   = ssgf_pkg::RECIP_SHIFT;

   ssgf_pkg::slot_tag_type s2_tag_ff, s3_tag_ff;
   logic [IDX_W-1:0]       s2_j_ff, s3_j_ff;
   logic [PROD_W-1:0]      s2_prod_ff, s2_prod_in;
   logic [SUM_W-1:0]       s2_sum_ff;
   logic [CNT_W-1:0]       s2_cnt_ff;
   logic [DATA_W-1:0]      s3_avg_ff, s3_avg_in;

   logic [DATA_W-1:0] q_est;
   logic [SUM_W-1:0]  q_back;
   logic [SUM_W-1:0]  q_rem;

   // Quotient estimate: sum times the truncated reciprocal of the count.
   assign s2_prod_in = PROD_W'(s1_sum) * PROD_W'(ssgf_pkg::recip(RIW'(s1_cnt)));

   // The estimate is low by at most one; the remainder decides.
   assign q_est     = s2_prod_ff[SHIFT +: DATA_W];
   assign q_back    = SUM_W'(q_est) * SUM_W'(s2_cnt_ff);
   assign q_rem     = s2_sum_ff - q_back;
   assign s3_avg_in = (q_rem >= SUM_W'(s2_cnt_ff)) ? q_est + DATA_W'(1) : q_est;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else if (adv) begin
         s2_tag_ff <= s1_tag;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_j_ff    <= s1_j;
         s2_prod_ff <= s2_prod_in;
         s2_sum_ff  <= s1_sum;
         s2_cnt_ff  <= s1_cnt;
         s3_j_ff    <= s2_j_ff;
         s3_avg_ff  <= s3_avg_in;
      end
   end

   assign s3_tag = s3_tag_ff;
   assign s3_j   = s3_j_ff;
   assign s3_avg = s3_avg_ff;

endmodule

### rtl/ssgf_track.sv
// Running maximum and widest run of bins at that maximum, first run wins a
// tie. Gives the mid-run index and range for the result. Depends on ssgf_pkg.
module ssgf_track #(
   parameter int NUM_BINS = 1080
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  ssgf_pkg::slot_tag_type            s3_tag,
   input  logic [$clog2(NUM_BINS)-1:0]       s3_j,
   input  logic [ssgf_pkg::DATA_W-1:0]       s3_avg,
   output logic [ssgf_pkg::GAP_W-1:0]        res_index,
   output logic [ssgf_pkg::DATA_W-1:0]       res_range
);

   localparam int DATA_W = ssgf_pkg::DATA_W;
   localparam int GAP_W  = ssgf_pkg::GAP_W;
   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int LEN_W  = $clog2(NUM_BINS + 1);

   logic [DATA_W-1:0] max_ff, max_in;
   logic [IDX_W-1:0]  run_start_ff, run_start_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;
   logic [IDX_W-1:0]  best_start_ff, best_start_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic              prev_max_ff, prev_max_in;
   logic [LEN_W-1:0]  mid;

   // Run bookkeeping for one smoothed bin.
   always_comb begin
      max_in        = max_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      prev_max_in   = prev_max_ff;
      if (adv && s3_tag.valid) begin
         if (s3_tag.first || s3_avg > max_ff) begin
            // New maximum starts a fresh run and a fresh best.
            max_in        = s3_avg;
            run_start_in  = s3_j;
            run_len_in    = LEN_W'(1);
            best_start_in = s3_j;
            best_len_in   = LEN_W'(1);
            prev_max_in   = 1'b1;
         end else if (s3_avg == max_ff) begin
            if (prev_max_ff) begin
               run_len_in = run_len_ff + LEN_W'(1);
            end else begin
               run_start_in = s3_j;
               run_len_in   = LEN_W'(1);
            end
            if (run_len_in > best_len_ff) begin
               best_start_in = run_start_in;
               best_len_in   = run_len_in;
            end
            prev_max_in = 1'b1;
         end else begin
            prev_max_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff        <= '0;
         run_start_ff  <= '0;
         run_len_ff    <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         prev_max_ff   <= 1'b0;
      end else begin
         max_ff        <= max_in;
         run_start_ff  <= run_start_in;
         run_len_ff    <= run_len_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         prev_max_ff   <= prev_max_in;
      end
   end

   // Middle of the best run, taken from the state that includes this bin.
   assign mid       = LEN_W'(best_start_in) + (best_len_in >> 1);
   assign res_index = GAP_W'(mid);
   assign res_range = max_in;

endmodule

### rtl/scan_smooth_widest_gap_finder.sv
// Top level of the scan gap finder: handshakes, configuration registers and
// the result register. Uses ssgf_pkg, ssgf_window, ssgf_divide, ssgf_track.
//
//   Channel  Dir  Handshake               Payload
//   req      in   req_tvalid/req_tready   tdata range_sample, tlast last_bin
//   rsp      out  rsp_tvalid/rsp_tready   tdata gap_index, gap_range
//   csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// One range sample is taken per cycle while req_tready is high. The closing
// window of a scan drains one bin per cycle while the pipeline advances, then
// passes two divider stages and the run tracker into the result register.
// A closing sample waits while the previous scan still has more than one
// drain slot left, which only happens for scans of at most SMOOTH_WINDOW/2 bins.
// The pipeline stops only when a scan result meets an untaken earlier one.
// Reset empties the window and sets the limits to 0.1 m and 20 m.
`include "assert_macros.svh"

module scan_smooth_widest_gap_finder #(
   parameter int NUM_BINS      = 1080,
   parameter int SMOOTH_WINDOW = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample transactions.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,   // [15:0] range_sample
   input  logic                                 req_tlast,   // last_bin
   // Result transactions.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ssgf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [10:0] gap_index,
                                                             // [26:11] gap_range
   // Register write transactions.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [0:0]                           csr_index,
   input  logic [ssgf_pkg::DATA_W-1:0]          csr_data
);

   localparam int DATA_W = ssgf_pkg::DATA_W;
   localparam int GAP_W  = ssgf_pkg::GAP_W;
   localparam int HALF   = SMOOTH_WINDOW / 2;
   localparam int SPAN   = 2 * HALF + 1;
   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int CNT_W  = $clog2(SPAN + 1);
   localparam int SUM_W  = DATA_W + $clog2(SPAN);

   logic [DATA_W-1:0] min_valid_ff;
   logic [DATA_W-1:0] max_range_ff;
   logic              rsp_valid_ff;
   logic [ssgf_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic adv;
   logic accept;
   logic last_eff;
   logic tail_hold;

   ssgf_pkg::slot_tag_type s1_tag, s3_tag;
   logic [IDX_W-1:0]       s1_j, s3_j;
   logic [SUM_W-1:0]       s1_sum;
   logic [CNT_W-1:0]       s1_cnt;
   logic [DATA_W-1:0]      s3_avg;
   logic [GAP_W-1:0]       res_index;
   logic [DATA_W-1:0]      res_range;

   // The pipeline halts only when a new result would overwrite a waiting one.
   assign adv        = !(s3_tag.done && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv && !(last_eff && tail_hold);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ssgf_window #(
      .NUM_BINS      (NUM_BINS),
      .SMOOTH_WINDOW (SMOOTH_WINDOW)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .accept          (accept),
      .range_sample    (req_tdata),
      .last_bin        (req_tlast),
      .min_valid_range (min_valid_ff),
      .clamp_range     (max_range_ff),
      .last_eff        (last_eff),
      .tail_hold       (tail_hold),
      .s1_tag          (s1_tag),
      .s1_j            (s1_j),
      .s1_sum          (s1_sum),
      .s1_cnt          (s1_cnt)
   );

   ssgf_divide #(
      .NUM_BINS      (NUM_BINS),
      .SMOOTH_WINDOW (SMOOTH_WINDOW)
   ) u_divide (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .s1_tag (s1_tag),
      .s1_j   (s1_j),
      .s1_sum (s1_sum),
      .s1_cnt (s1_cnt),
      .s3_tag (s3_tag),
      .s3_j   (s3_j),
      .s3_avg (s3_avg)
   );

   ssgf_track #(
      .NUM_BINS (NUM_BINS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s3_tag    (s3_tag),
      .s3_j      (s3_j),
      .s3_avg    (s3_avg),
      .res_index (res_index),
      .res_range (res_range)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= ssgf_pkg::MIN_VALID_RESET;
         max_range_ff <= ssgf_pkg::MAX_RANGE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (ssgf_pkg::csr_reg_type'(csr_index))
            ssgf_pkg::CSR_MIN_VALID_RANGE: min_valid_ff <= csr_data;
            ssgf_pkg::CSR_MAX_RANGE:       max_range_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Result register, loaded when the closing slot of a scan is tracked.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s3_tag.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_tag.done) begin
         rsp_data_ff <= {{ssgf_pkg::RSP_PAD_W{1'b0}}, res_range, res_index};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A reported gap lies inside the scan.
   `ASSERT_HOLDS(a_index_in_scan, !rsp_valid_ff || rsp_data_ff[GAP_W-1:0] < GAP_W'(NUM_BINS),
      "gap index beyond the scan")
   // Smoothed ranges never exceed the clamp value.
   `ASSERT_HOLDS(a_range_clamped, !rsp_valid_ff || rsp_data_ff[GAP_W +: DATA_W] <= max_range_ff,
      "gap range above the maximum range")
   // A result that meets a waiting one is kept, not dropped.
   `ASSERT_NEXT(a_result_kept, s3_tag.done && rsp_valid_ff && !rsp_tready, s3_tag.done,
      "scan result lost while the output was stalled")
   // A taken result is not shown twice.
   `ASSERT_NEXT(a_result_once, rsp_valid_ff && rsp_tready && !s3_tag.done, !rsp_valid_ff,
      "scan result repeated")

endmodule
